[sv/shp3_pkg.sv]
// ----------------------------------------------------------------------------
// shp3_pkg
// Shared types and constants of the 3x3 sharpen stream block.
// ----------------------------------------------------------------------------
package shp3_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CHANS  = 2'd2;
    localparam logic [1:0] CFG_GAIN   = 2'd3;

    localparam logic [11:0] RST_WIDTH  = 12'd1280;
    localparam logic [11:0] RST_HEIGHT = 12'd720;
    localparam logic [1:0]  RST_CHANS  = 2'd3;
    localparam logic [7:0]  RST_GAIN   = 8'd64;

    localparam logic [11:0] HEIGHT_MIN = 12'd3;
    localparam logic [11:0] HEIGHT_MAX = 12'd2048;

    // control toward the window front end
    typedef struct packed {
        logic        en;
        logic        restart;
        logic [11:0] width;
        logic [11:0] height;
        logic [1:0]  nch;
    } t_win_ctl;

    // control toward each filter lane
    typedef struct packed {
        logic       en;
        logic [7:0] gain;
    } t_lane_ctl;

    // per-pixel tag carried down the pipeline
    typedef struct packed {
        logic valid;
        logic produce;
        logic frame_end;
    } t_tag;

endpackage

[sv/shp3_ram.sv]
// ----------------------------------------------------------------------------
// shp3_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module shp3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/shp3_window.sv]
// ----------------------------------------------------------------------------
// shp3_window
// Raster position counters, two line stores and the 3x3 pixel window.
// ----------------------------------------------------------------------------
module shp3_window
    import shp3_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int LANES     = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_win_ctl             i_ctl,
    input  logic                 i_in_valid,
    input  logic [7:0]           i_samples [0:2],
    output logic [LANES*8-1:0]   o_win [0:8],
    output t_tag                 o_tag
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (EW > 12) ? EW : 12;
    localparam int PW = LANES * 8;

    logic [CW-1:0] w_raw, w_eff, w_last;
    logic [11:0]   h_eff, h_last;
    logic          accept, col_end, row_end;
    logic [PW-1:0] pix;
    logic [PW-1:0] rd_prev, rd_bp;

    logic [AW-1:0] r_col, n_col;
    logic [10:0]   r_row, n_row;
    logic          r_s1_valid;
    logic [PW-1:0] r_s1_pix;
    logic [AW-1:0] r_s1_col;
    t_tag          r_s1_tag;
    t_tag          r_s2_tag;
    logic [PW-1:0] r_win [0:8];

    always_comb begin
        w_raw = CW'(i_ctl.width);
        if (w_raw < CW'(3)) begin
            w_eff = CW'(3);
        end else if (w_raw > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        w_last = w_eff - CW'(1);

        if (i_ctl.height < HEIGHT_MIN) begin
            h_eff = HEIGHT_MIN;
        end else if (i_ctl.height > HEIGHT_MAX) begin
            h_eff = HEIGHT_MAX;
        end else begin
            h_eff = i_ctl.height;
        end
        h_last = h_eff - 12'd1;
    end

    assign accept  = i_in_valid && i_ctl.en;
    assign col_end = (CW'(r_col) == w_last);
    assign row_end = ({1'b0, r_row} == h_last);

    // unused channels go into the stores as zero
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            pix[l*8 +: 8] = (2'(l) < i_ctl.nch) ? i_samples[l] : 8'd0;
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_ctl.restart) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? 11'd0 : r_row + 11'd1;
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_tag   <= '0;
            r_s2_tag   <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_ctl.en) begin
                r_s1_valid         <= accept;
                r_s1_tag.valid     <= accept;
                r_s1_tag.produce   <= (r_row >= 11'd2) && (r_col >= AW'(2));
                r_s1_tag.frame_end <= row_end && col_end;
                r_s2_tag           <= r_s1_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= pix;
            r_s1_col <= r_col;
        end
        if (i_ctl.en && r_s1_valid) begin
            for (int rr = 0; rr < 3; rr++) begin
                r_win[rr*3]     <= r_win[rr*3 + 1];
                r_win[rr*3 + 1] <= r_win[rr*3 + 2];
            end
            r_win[2] <= rd_bp;
            r_win[5] <= rd_prev;
            r_win[8] <= r_s1_pix;
        end
    end

    shp3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_prev (
        .i_clk   (i_clk),
        .i_we    (i_ctl.en && r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd_prev)
    );

    // the row above moves down one store
    shp3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_bp (
        .i_clk   (i_clk),
        .i_we    (i_ctl.en && r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (rd_prev),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd_bp)
    );

    assign o_win = r_win;
    assign o_tag = r_s2_tag;

endmodule

[sv/shp3_lane.sv]
// ----------------------------------------------------------------------------
// shp3_lane
// Sharpen kernel for one color channel: neighbor sum, weighting, clamp.
// ----------------------------------------------------------------------------
module shp3_lane
    import shp3_pkg::*;
(
    input  logic       i_clk,
    input  t_lane_ctl  i_ctl,
    input  logic [7:0] i_taps [0:8],
    output logic [7:0] o_sharp
);

    logic [10:0] nsum;
    logic [8:0]  center_wt;
    logic [20:0] acc;
    logic [12:0] quot;

    logic [7:0]  r_center;
    logic [10:0] r_nsum;
    logic [19:0] r_pos;
    logic [18:0] r_neg;

    always_comb begin
        nsum = 11'd0;
        for (int t = 0; t < 9; t++) begin
            if (t != 4) begin
                nsum = nsum + 11'(i_taps[t]);
            end
        end
    end

    assign center_wt = {1'b0, i_ctl.gain} + 9'd16;

    // units of 1/128: 8*(gain+16)*center - gain*neighbors
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_center <= i_taps[4];
            r_nsum   <= nsum;
            r_pos    <= {17'(r_center) * 17'(center_wt), 3'b000};
            r_neg    <= 19'(i_ctl.gain) * 19'(r_nsum);
        end
    end

    assign acc  = {1'b0, r_pos} - {2'b00, r_neg};
    assign quot = acc[19:7];

    always_comb begin
        if (acc[20]) begin
            o_sharp = 8'd0;
        end else if (|quot[12:8]) begin
            o_sharp = 8'd255;
        end else begin
            o_sharp = quot[7:0];
        end
    end

endmodule

[sv/sharpen_3x3_stream.sv]
// ----------------------------------------------------------------------------
// sharpen_3x3_stream
// 3x3 sharpen filter on a raster pixel stream, one lane per color channel.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  pixel in | input     | i_in_valid/o_in_stall | i_sample_a/b/c
//  result   | output    | o_out_valid/i_out_stall | o_sharp_a/b/c, o_frame_end
//  config   | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one pixel per cycle sustained while no result is held; each pixel
//  passes the line store read, the window, two lane stages and the
//  output register before its result appears.
//  only interior pixels give a result, so bubbles follow border pixels.
//  synchronous active-low reset clears counters and valid bits; stores are
//  not cleared. a held result freezes the whole pipeline and stalls input.
// ----------------------------------------------------------------------------
module sharpen_3x3_stream
    import shp3_pkg::*;
#(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_sample_a,
    input  logic [7:0]  i_sample_b,
    input  logic [7:0]  i_sample_c,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_sharp_a,
    output logic [7:0]  o_sharp_b,
    output logic [7:0]  o_sharp_c,
    output logic        o_frame_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    localparam int LANES = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;

    logic               en, cfg_write;
    logic [1:0]         nch;
    logic [7:0]         samples [0:2];
    logic [LANES*8-1:0] win [0:8];
    logic [7:0]         lane_res [0:2];
    t_win_ctl           win_ctl;
    t_lane_ctl          lane_ctl;
    t_tag               win_tag;

    logic [11:0] r_width, r_height;
    logic [1:0]  r_chans;
    logic [7:0]  r_gain;
    t_tag        r_t3, r_t4;
    logic        r_out_valid, r_frame_end;
    logic [7:0]  r_sharp [0:2];

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;
    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_chans  <= RST_CHANS;
            r_gain   <= RST_GAIN;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_CHANS:  r_chans  <= i_cfg_data[1:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[7:0];
            endcase
        end
    end

    always_comb begin
        if (r_chans == 2'd0) begin
            nch = 2'd1;
        end else if (r_chans > 2'(LANES)) begin
            nch = 2'(LANES);
        end else begin
            nch = r_chans;
        end
    end

    assign samples[0] = i_sample_a;
    assign samples[1] = i_sample_b;
    assign samples[2] = i_sample_c;

    assign win_ctl  = '{en: en, restart: cfg_write, width: r_width,
                        height: r_height, nch: nch};
    assign lane_ctl = '{en: en, gain: r_gain};

    shp3_window #(.MAX_WIDTH(MAX_WIDTH), .LANES(LANES)) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (win_ctl),
        .i_in_valid (i_in_valid),
        .i_samples  (samples),
        .o_win      (win),
        .o_tag      (win_tag)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [7:0] taps [0:8];
        for (genvar t = 0; t < 9; t++) begin : g_tap
            assign taps[t] = win[t][l*8 +: 8];
        end
        shp3_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (lane_ctl),
            .i_taps  (taps),
            .o_sharp (lane_res[l])
        );
    end

    for (genvar l = LANES; l < 3; l++) begin : g_unused
        assign lane_res[l] = 8'd0;
    end

    // carry the tags beside the lanes into the output valid and frame flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t3        <= '0;
            r_t4        <= '0;
            r_out_valid <= 1'b0;
            r_frame_end <= 1'b0;
        end else if (en) begin
            r_t3        <= win_tag;
            r_t4        <= r_t3;
            r_out_valid <= r_t4.valid && r_t4.produce;
            r_frame_end <= r_t4.valid && r_t4.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_sharp[l] <= (2'(l) < nch) ? lane_res[l] : 8'd0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_frame_end = r_frame_end;
    assign o_sharp_a   = r_sharp[0];
    assign o_sharp_b   = r_sharp[1];
    assign o_sharp_c   = r_sharp[2];

endmodule

[sv/shp3_checker.sv]
// ----------------------------------------------------------------------------
// shp3_checker
// Port-level checks of the sharpen stream block, bound to the top level.
// ----------------------------------------------------------------------------
module shp3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_sharp_a,
    input logic [7:0]  o_sharp_b,
    input logic [7:0]  o_sharp_c,
    input logic        o_frame_end
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // input backs up only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sharp_a)
            && $stable(o_sharp_b) && $stable(o_sharp_c) && $stable(o_frame_end)))
        else $error("held result changed");

    // the frame flag rides only on a result
    a_frame_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_end |-> o_out_valid)
        else $error("frame end without a result");

endmodule

bind sharpen_3x3_stream shp3_checker u_checker (.*);

[sim/sharpen_3x3_stream_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_3x3_stream_test
// Self-checking bench for the 3x3 sharpen stream: pixel frames of many shapes,
// gains and channel counts go in with random gaps and stalls on both sides,
// and every interior result is compared with a cycle-free model of the filter.
// ----------------------------------------------------------------------------
import shp3_pkg::*;

typedef struct packed {
    logic [7:0] ch_a;
    logic [7:0] ch_b;
    logic [7:0] ch_c;
    logic       frame_end;
} t_sharp_pixel;

class sharpen_board;
    localparam int LINE_DEPTH = 2048;

    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [1:0]  chans_reg;
    logic [7:0]  gain_reg;
    logic [23:0] line_prev [LINE_DEPTH];
    logic [23:0] line_prev2 [LINE_DEPTH];
    logic [23:0] win [9];
    int unsigned col;
    int unsigned row;
    t_sharp_pixel sharp_due [$];
    int unsigned pixels_noted;
    int unsigned results_seen;
    int unsigned writes;
    int unsigned failures;

    function new();
        width_reg  = RST_WIDTH;
        height_reg = RST_HEIGHT;
        chans_reg  = RST_CHANS;
        gain_reg   = RST_GAIN;
        foreach (line_prev[i]) begin
            line_prev[i]  = '0;
            line_prev2[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        col = 0;
        row = 0;
        pixels_noted = 0;
        results_seen = 0;
        writes = 0;
        failures = 0;
    endfunction

    function int unsigned line_width();
        int unsigned w;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        return w;
    endfunction

    function int unsigned frame_height();
        int unsigned h;
        h = height_reg;
        if (h < HEIGHT_MIN) h = HEIGHT_MIN;
        if (h > HEIGHT_MAX) h = HEIGHT_MAX;
        return h;
    endfunction

    function int unsigned lanes();
        return (chans_reg == 2'd0) ? 1 : chans_reg;
    endfunction

    function int unsigned frame_size();
        return line_width() * frame_height();
    endfunction

    // any write restarts the frame, line stores are kept
    function void write_reg(logic [1:0] idx, logic [11:0] val);
        case (idx)
            CFG_WIDTH:  width_reg  = val;
            CFG_HEIGHT: height_reg = val;
            CFG_CHANS:  chans_reg  = val[1:0];
            CFG_GAIN:   gain_reg   = val[7:0];
        endcase
        col = 0;
        row = 0;
        writes++;
    endfunction

    // exact sum in 1/128 units, negative clamps to zero
    function logic [7:0] lane_value(int ch);
        longint center;
        longint nsum;
        longint acc;
        int t;
        center = win[4][8*ch +: 8];
        nsum = 0;
        for (t = 0; t < 9; t++)
            if (t != 4) nsum += win[t][8*ch +: 8];
        acc = 8 * (longint'(gain_reg) + 16) * center - longint'(gain_reg) * nsum;
        if (acc < 0) return 8'h00;
        acc = acc >>> 7;
        if (acc > 255) return 8'hFF;
        return acc[7:0];
    endfunction

    function void take_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned cc;
        int unsigned rr;
        logic [23:0] pix;
        logic [23:0] up1;
        logic [23:0] up2;
        t_sharp_pixel want;
        w = line_width();
        h = frame_height();
        n = lanes();
        cc = (col >= w) ? 0 : col;
        rr = (row >= h) ? 0 : row;
        pix = {(n > 2) ? c : 8'h00, (n > 1) ? b : 8'h00, a};
        up2 = line_prev2[cc];
        up1 = line_prev[cc];
        for (int k = 0; k < 3; k++) begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = pix;
        line_prev2[cc] = up1;
        line_prev[cc]  = pix;
        if (rr >= 2 && cc >= 2) begin
            want.ch_a = lane_value(0);
            want.ch_b = (n > 1) ? lane_value(1) : 8'h00;
            want.ch_c = (n > 2) ? lane_value(2) : 8'h00;
            want.frame_end = (rr == h - 1) && (cc == w - 1);
            sharp_due.push_back(want);
        end
        cc++;
        if (cc >= w) begin
            cc = 0;
            rr++;
            if (rr >= h) rr = 0;
        end
        col = cc;
        row = rr;
        pixels_noted++;
    endfunction

    function void compare_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        end
    endfunction

    function void match_result(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic fe);
        t_sharp_pixel want;
        results_seen++;
        if (sharp_due.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none actual %0d/%0d/%0d end %0b",
                     $time, a, b, c, fe);
            return;
        end
        want = sharp_due.pop_front();
        compare_field("sharp_a", want.ch_a, a);
        compare_field("sharp_b", want.ch_b, b);
        compare_field("sharp_c", want.ch_c, c);
        compare_field("frame_end", {7'd0, want.frame_end}, {7'd0, fe});
    endfunction
endclass

module sharpen_3x3_stream_test;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_PIXELS = 240;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_sample_a;
    logic [7:0]  i_sample_b;
    logic [7:0]  i_sample_c;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_sharp_a;
    logic [7:0]  o_sharp_b;
    logic [7:0]  o_sharp_c;
    logic        o_frame_end;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    sharpen_board board;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  hold_request = 0;
    int unsigned  hold_left = 0;
    int unsigned  cycle_count = 0;

    sharpen_3x3_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_a  (i_sample_a),
        .i_sample_b  (i_sample_b),
        .i_sample_c  (i_sample_c),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sharp_a   (o_sharp_a),
        .o_sharp_b   (o_sharp_b),
        .o_sharp_c   (o_sharp_c),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, board.sharp_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output side: random stall, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.match_result(o_sharp_a, o_sharp_b, o_sharp_c, o_frame_end);
    end

    function automatic logic [7:0] pick_sample(bit harsh);
        if (harsh) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_sample_a <= a;
        i_sample_b <= b;
        i_sample_c <= c;
        do @(posedge i_clk); while (o_in_stall);
        board.take_pixel(a, b, c);
    endtask

    // stop offering pixels until every result is back and border pixels drained
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.sharp_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frames(input int unsigned frames, input bit allow_partial);
        int unsigned count;
        bit harsh;
        harsh = ($urandom_range(3) == 0);
        for (int f = 0; f < frames; f++) begin
            count = board.frame_size();
            // cut the last frame short now and then, the next write restarts it
            if (allow_partial && f == frames - 1 && $urandom_range(3) == 0)
                count = $urandom_range(1, count - 1);
            repeat (count) send_pixel(pick_sample(harsh), pick_sample(harsh), pick_sample(harsh));
        end
    endtask

    task automatic random_segment(input bit squeeze);
        bit all_regs;
        settle();
        all_regs = ($urandom_range(3) == 0);
        if (all_regs || $urandom_range(1))
            write_reg(CFG_WIDTH, ($urandom_range(9) == 0) ? 12'($urandom_range(2))
                                                           : 12'($urandom_range(3, 12)));
        if (all_regs || $urandom_range(1))
            write_reg(CFG_HEIGHT, ($urandom_range(9) == 0) ? 12'($urandom_range(2))
                                                            : 12'($urandom_range(3, 8)));
        if (all_regs || $urandom_range(1))
            write_reg(CFG_CHANS, {10'($urandom_range(1023)), 2'($urandom_range(3))});
        if (all_regs || $urandom_range(1)) begin
            case ($urandom_range(5))
                0:       write_reg(CFG_GAIN, {4'($urandom_range(15)), 8'h00});
                1:       write_reg(CFG_GAIN, {4'($urandom_range(15)), 8'hFF});
                default: write_reg(CFG_GAIN, 12'($urandom_range(4095)));
            endcase
        end
        if (squeeze) begin
            // enough interior pixels to back the pipeline up into the input
            write_reg(CFG_WIDTH, 12'd10);
            write_reg(CFG_HEIGHT, 12'd8);
            hold_request = 80;
            send_frames(3, 1'b0);
        end else begin
            send_frames($urandom_range(1, 3), 1'b1);
        end
    endtask

    initial begin
        int unsigned mark;
        int unsigned seg;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_a  = '0;
        i_sample_b  = '0;
        i_sample_c  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data  = '0;
        board = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 51;

        // smallest frame, top gain: bright center clamps high, dark center clamps low
        write_reg(CFG_WIDTH, 12'd3);
        write_reg(CFG_HEIGHT, 12'd3);
        write_reg(CFG_CHANS, 12'd3);
        write_reg(CFG_GAIN, 12'd255);
        for (int k = 0; k < 9; k++)
            send_pixel((k == 4) ? 8'hFF : 8'h00, (k == 4) ? 8'h00 : 8'hFF,
                       8'($urandom_range(255)));
        settle();
        // zero gain passes the center through, channel count zero means one lane
        write_reg(CFG_GAIN, 12'hA00);
        write_reg(CFG_CHANS, 12'hFFC);
        for (int k = 0; k < 9; k++)
            send_pixel(8'($urandom_range(255)), 8'hFF, 8'hFF);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 15; recv_idle_pct = 51; end
                1: begin send_idle_pct = 51; recv_idle_pct = 15; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            mark = board.pixels_noted;
            seg = 0;
            while (board.pixels_noted - mark < PHASE_PIXELS) begin
                random_segment(phase == 0 && seg == 0);
                seg++;
            end
        end

        settle();

        $display("covered %0d pixels and %0d sharpened results over %0d register writes",
                 board.pixels_noted, board.results_seen, board.writes);
        $display("frames from 3x3 up to 12x8 with saturated sizes, gain 0..255, 1..3 channels");
        if (board.failures == 0 && board.sharp_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/shp3_pkg.sv
sv/shp3_ram.sv
sv/shp3_window.sv
sv/shp3_lane.sv
sv/sharpen_3x3_stream.sv
sv/shp3_checker.sv
sim/sharpen_3x3_stream_test.sv
